### rtl/core/srwu_pkg.sv
package srwu_pkg;

  localparam int unsigned SnrW     = 32;
  localparam int unsigned ApW      = 16;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned QuoW     = 30;
  localparam int unsigned RootW    = 15;
  localparam int unsigned RemW     = RootW + 2;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned SqrtSteps = RootW;

  localparam logic [ApW-1:0]     OneQ15       = 16'h8000;
  localparam logic [SnrW-1:0]    LowerRstVal  = 32'h0000_0000;
  localparam logic [SnrW-1:0]    UpperRstVal  = 32'h0001_0000;

  typedef enum logic {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic               use_root;
    logic [WeightW-1:0] weight;
    logic               stabilize;
  } side_t;

  typedef struct packed {
    logic [SnrW-1:0] rem;
    logic [SnrW-1:0] den;
    logic [QuoW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [QuoW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

endpackage

### rtl/core/srwu_div_cell.sv
module srwu_div_cell
  import srwu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  div_t  data_i,
  input  side_t side_i,
  output logic  valid_o,
  output div_t  data_o,
  output side_t side_o
);

  logic [SnrW:0] shifted;
  logic          ge;
  logic [SnrW:0] diff;
  div_t          data_d, data_q;
  side_t         side_q;
  logic          valid_q;

  always_comb begin
    shifted = {data_i.rem, 1'b0};
    ge      = shifted >= {1'b0, data_i.den};
    diff    = shifted - {1'b0, data_i.den};
    data_d.den = data_i.den;
    data_d.rem = ge ? diff[SnrW-1:0] : shifted[SnrW-1:0];
    data_d.quo = {data_i.quo[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign side_o  = side_q;

endmodule

### rtl/core/srwu_sqrt_cell.sv
module srwu_sqrt_cell
  import srwu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  sqrt_t data_i,
  input  side_t side_i,
  output logic  valid_o,
  output sqrt_t data_o,
  output side_t side_o
);

  logic [RemW+1:0] cand;
  logic [RemW+1:0] trial;
  logic [RemW+1:0] diff;
  logic            ge;
  sqrt_t           data_d, data_q;
  side_t           side_q;
  logic            valid_q;

  always_comb begin
    cand  = {data_i.rem, data_i.rad[QuoW-1 -: 2]};
    trial = {2'b00, data_i.root, 2'b01};
    ge    = cand >= trial;
    diff  = cand - trial;
    data_d.rad  = {data_i.rad[QuoW-3:0], 2'b00};
    data_d.rem  = ge ? diff[RemW-1:0] : cand[RemW-1:0];
    data_d.root = {data_i.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign side_o  = side_q;

endmodule

### rtl/core/snr_regularization_weight_unit.sv
// Throughput: one item per cycle while the output buffer has a free entry; set
// by a chain of 30 one-bit divider cells and 15 one-bit square-root cells, each
// a single pipeline register.
// A two-entry output buffer keeps the input open while one result waits.
// Reset clears all valid bits; lower threshold resets to 0, upper to 1.0.
module snr_regularization_weight_unit
  import srwu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [SnrW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,   // snr[31:0], aperture[47:32]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata    // weight[15:0], stabilize[16], zero[23:17]
);

  logic [SnrW-1:0] lower_q, upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LowerRstVal;
      upper_q <= UpperRstVal;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_LOWER: lower_q <= cfg_data_i;
        REG_UPPER: upper_q <= cfg_data_i;
        default:   lower_q <= lower_q;
      endcase
    end
  end

  logic en;
  logic skid_vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  logic [SnrW-1:0] snr;
  logic [ApW-1:0]  ap;
  side_t           side_in;
  div_t            div_in;

  always_comb begin
    snr = s_axis_tdata[SnrW-1:0];
    ap  = s_axis_tdata[SnrW +: ApW];
    side_in.use_root  = 1'b0;
    side_in.weight    = '0;
    side_in.stabilize = 1'b0;
    div_in.rem = snr - lower_q;
    div_in.den = upper_q - lower_q;
    div_in.quo = '0;
    if (ap == OneQ15) begin
      priority if (snr >= upper_q) begin
        side_in.weight = OneQ15;
      end else if (snr >= lower_q) begin
        side_in.use_root = 1'b1;
      end else begin
        side_in.weight = '0;
      end
    end else begin
      side_in.weight    = (ap < OneQ15) ? (OneQ15 - ap) : (ap - OneQ15);
      side_in.stabilize = snr < lower_q;
    end
  end

  logic  div_vld  [DivSteps+1];
  div_t  div_dat  [DivSteps+1];
  side_t div_side [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld[0] <= 1'b0;
    end else if (en) begin
      div_vld[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_dat[0]  <= div_in;
      div_side[0] <= side_in;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    srwu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_vld[k]),
      .data_i  (div_dat[k]),
      .side_i  (div_side[k]),
      .valid_o (div_vld[k+1]),
      .data_o  (div_dat[k+1]),
      .side_o  (div_side[k+1])
    );
  end

  logic  sq_vld  [SqrtSteps+1];
  sqrt_t sq_dat  [SqrtSteps+1];
  side_t sq_side [SqrtSteps+1];

  assign sq_vld[0]      = div_vld[DivSteps];
  assign sq_side[0]     = div_side[DivSteps];
  assign sq_dat[0].rad  = div_dat[DivSteps].quo;
  assign sq_dat[0].rem  = '0;
  assign sq_dat[0].root = '0;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    srwu_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[k]),
      .data_i  (sq_dat[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_vld[k+1]),
      .data_o  (sq_dat[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  logic [23:0] res_data;
  logic [WeightW-1:0] res_weight;
  logic push;

  assign res_weight = sq_side[SqrtSteps].use_root
                    ? {1'b0, sq_dat[SqrtSteps].root}
                    : sq_side[SqrtSteps].weight;
  assign res_data   = {7'b0000000, sq_side[SqrtSteps].stabilize, res_weight};
  assign push       = en && sq_vld[SqrtSteps];

  logic        out_vld_q, out_vld_d, skid_vld_d;
  logic [23:0] out_data_q, out_data_d, skid_data_q, skid_data_d;

  always_comb begin
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;
    skid_vld_d  = skid_vld_q;
    skid_data_d = skid_data_q;
    if (out_vld_q && !m_axis_tready) begin
      if (push) begin
        skid_vld_d  = 1'b1;
        skid_data_d = res_data;
      end
    end else if (skid_vld_q) begin
      out_vld_d  = 1'b1;
      out_data_d = skid_data_q;
      skid_vld_d = 1'b0;
    end else begin
      out_vld_d  = push;
      out_data_d = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### sim/snr_regularization_weight_unit_test.sv
`timescale 1ns / 100ps

module snr_regularization_weight_unit_test;
  import srwu_pkg::*;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic               stabilize;
  } weight_result_t;

  class pixel_weight_checker;
    logic [SnrW-1:0] lower_thr;
    logic [SnrW-1:0] upper_thr;
    weight_result_t  expected_q[$];
    int unsigned     fail_count;

    function new();
      lower_thr  = LowerRstVal;
      upper_thr  = UpperRstVal;
      fail_count = 0;
    endfunction

    function void set_thresholds(logic [SnrW-1:0] lower, logic [SnrW-1:0] upper);
      lower_thr = lower;
      upper_thr = upper;
    endfunction

    function logic [WeightW-1:0] floor_root(logic [QuoW-1:0] v);
      logic [31:0] cand;
      logic [31:0] root;
      root = '0;
      for (int b = RootW - 1; b >= 0; b--) begin
        cand = root | (32'd1 << b);
        if (cand * cand <= {2'b00, v}) root = cand;
      end
      return root[WeightW-1:0];
    endfunction

    function void note_pixel(logic [SnrW-1:0] snr, logic [ApW-1:0] ap);
      weight_result_t res;
      logic [63:0]    quo;
      res.stabilize = 1'b0;
      if (ap == OneQ15) begin
        if (snr >= upper_thr) begin
          res.weight = OneQ15;
        end else if (snr >= lower_thr) begin
          quo = {32'd0, snr - lower_thr} << QuoW;
          quo = quo / {32'd0, upper_thr - lower_thr};
          res.weight = floor_root(quo[QuoW-1:0]);
        end else begin
          res.weight = '0;
        end
      end else begin
        res.weight    = (ap < OneQ15) ? OneQ15 - ap : ap - OneQ15;
        res.stabilize = (snr < lower_thr);
      end
      expected_q.push_back(res);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string what, int unsigned want, int unsigned got);
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    endtask

    task check_result(logic [23:0] data);
      weight_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected transfer", 0, data[16:0]);
      end else begin
        want = expected_q.pop_front();
        if (data[15:0] !== want.weight) report("weight", want.weight, data[15:0]);
        if (data[16] !== want.stabilize) report("stabilize", want.stabilize, data[16]);
      end
    endtask

    task close();
      if (expected_q.size() != 0) report("missing results", 0, expected_q.size());
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic            cfg_idx_i     = REG_LOWER;
  logic [SnrW-1:0] cfg_data_i    = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [47:0]     s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [23:0]     m_axis_tdata;

  pixel_weight_checker weights = new();
  bit                  hold_output = 1'b0;
  int unsigned         src_quiet = 0;
  int unsigned         sink_quiet = 0;

  snr_regularization_weight_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(40, 150);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SnrW-1:0] pick_snr(logic [SnrW-1:0] lower, logic [SnrW-1:0] upper);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return lower + $urandom_range(0, 4) - 2;
      1: return upper + $urandom_range(0, 4) - 2;
      2: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      3, 4, 5, 6: begin
        if (upper > lower) return lower + ($urandom % (upper - lower));
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ApW-1:0] pick_aperture();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      5, 6: return 16'($urandom_range(0, 65535));
      7: return 16'($urandom_range(0, 32768));
      8: return 16'(OneQ15 + $urandom_range(0, 4) - 2);
      9: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'(OneQ15 - 1);
          default: return 16'(OneQ15 + 1);
        endcase
      end
      default: return OneQ15;
    endcase
  endfunction

  task automatic send_pixel(input logic [SnrW-1:0] snr, input logic [ApW-1:0] ap);
    int unsigned gap;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ap, snr};
    do @(negedge clk_i); while (!s_axis_tready);
    weights.note_pixel(snr, ap);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (weights.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_thresholds(input logic [SnrW-1:0] lower, input logic [SnrW-1:0] upper);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LOWER;
    cfg_data_i <= lower;
    @(posedge clk_i);
    cfg_idx_i  <= REG_UPPER;
    cfg_data_i <= upper;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    weights.set_thresholds(lower, upper);
  endtask

  // receiver side: random backpressure, one long hold-off on request
  initial begin
    int unsigned idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_output = 1'b0;
      end else if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else begin
        m_axis_tready <= 1'b1;
        idle_left = pick_gap(sink_quiet);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) weights.check_result(m_axis_tdata);
  end

  initial begin
    logic [SnrW-1:0] lo;
    logic [SnrW-1:0] hi;
    logic [SnrW-1:0] a;
    logic [SnrW-1:0] b;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: lower 0, upper 1.0
    send_pixel(32'h0000_0000, OneQ15);
    send_pixel(32'h0000_0001, OneQ15);
    send_pixel(32'h0000_4000, OneQ15);
    send_pixel(32'h0000_8000, OneQ15);
    send_pixel(32'h0000_FFFF, OneQ15);
    send_pixel(32'h0001_0000, OneQ15);
    send_pixel(32'h0001_0001, OneQ15);
    send_pixel(32'hFFFF_FFFF, OneQ15);
    send_pixel(32'h0000_0000, 16'h0000);
    send_pixel(32'hFFFF_FFFF, 16'h0001);
    send_pixel(32'h0000_8000, 16'(OneQ15 - 1));
    send_pixel(32'h0000_8000, 16'(OneQ15 + 1));
    send_pixel(32'h1234_5678, 16'hFFFF);
    send_pixel(32'h0000_0000, 16'h4000);

    // inverted thresholds, stabilize on both sides of lower
    drain();
    write_thresholds(32'h0002_0000, 32'h0001_0000);
    send_pixel(32'h0000_8000, OneQ15);
    send_pixel(32'h0001_0000, OneQ15);
    send_pixel(32'h0001_8000, OneQ15);
    send_pixel(32'h0002_0000, OneQ15);
    send_pixel(32'h0003_0000, OneQ15);
    send_pixel(32'h0001_FFFF, 16'd100);
    send_pixel(32'h0002_0000, 16'd100);

    for (int phase = 0; phase < 7; phase++) begin
      a = $urandom;
      b = $urandom;
      case (phase)
        0: begin lo = LowerRstVal;   hi = UpperRstVal;   end
        1: begin lo = 32'h0;         hi = 32'hFFFF_FFFF; end
        2: begin lo = 32'hFFFF_FFFF; hi = 32'hFFFF_FFFF; end
        3: begin lo = 32'h0;         hi = 32'h0;         end
        4: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
        5: begin lo = (a > b) ? b : a; hi = (a > b) ? a : b; end
        default: begin
          lo = $urandom_range(0, 32'hFFFF_FFFE);
          hi = lo + 1;
        end
      endcase
      drain();
      write_thresholds(lo, hi);
      if (phase == 1) hold_output = 1'b1;
      repeat (250) send_pixel(pick_snr(lo, hi), pick_aperture());
    end

    drain();
    weights.close();
    if (weights.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/srwu_pkg.sv
rtl/core/srwu_div_cell.sv
rtl/core/srwu_sqrt_cell.sv
rtl/core/snr_regularization_weight_unit.sv
sim/snr_regularization_weight_unit_test.sv
